### rtl/core/rrt_pkg.sv
// ----------------------------------------------------------------------------
// rrt_pkg
// Shared types, constants and helpers of the reflection ray tracer.
// ----------------------------------------------------------------------------
package rrt_pkg;

  localparam int QW               = 48;  // Q24.24 word
  localparam int FRAC             = 24;  // fraction bits
  localparam int AW_OP            = 50;  // multiplier A operand width
  localparam int MAX_SURFACES_DEF = 16;

  localparam logic signed [QW-1:0] QMAX = {1'b0, {(QW-1){1'b1}}};
  localparam logic signed [QW-1:0] QMIN = {1'b1, {(QW-1){1'b0}}};

  // Segment status codes
  localparam logic [2:0] ST_REFLECT = 3'd0;
  localparam logic [2:0] ST_DEST    = 3'd1;
  localparam logic [2:0] ST_BLOCKED = 3'd2;
  localparam logic [2:0] ST_NOHIT   = 3'd3;
  localparam logic [2:0] ST_LIMIT   = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_COUNT  = 2'd0;
  localparam logic [1:0] CFG_MAXREF = 2'd1;
  localparam logic [1:0] CFG_REACH  = 2'd2;

  // Reflector word selects
  localparam logic [2:0] WS_CENTER = 3'd0;
  localparam logic [2:0] WS_NORMAL = 3'd1;
  localparam logic [2:0] WS_LAXIS  = 3'd2;
  localparam logic [2:0] WS_WAXIS  = 3'd3;
  localparam logic [2:0] WS_SIZES  = 3'd4;

  localparam logic [4:0]  COUNT_RST  = 5'd1;
  localparam logic [3:0]  MAXREF_RST = 4'd3;
  localparam logic [3:0]  MAXREF_CAP = 4'd14;
  localparam logic [46:0] REACH_RST  = 47'd1677721600000;

  typedef logic signed [QW-1:0]    q_t;
  typedef logic signed [AW_OP-1:0] opa_t;

  typedef struct packed {
    logic start;
    logic dot;       // three terms when set, one term otherwise
  } mac_req_t;

  typedef struct packed {
    logic done;
    q_t   res;
  } mac_rsp_t;

  typedef struct packed {
    logic          start;
    logic [QW-1:0] num_mag;
    logic [QW-1:0] den_mag;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [QW:0] quot;
  } div_rsp_t;

  function automatic opa_t sx_op(input q_t v);
    return {{(AW_OP-QW){v[QW-1]}}, v};
  endfunction

  // Saturate an operand-width value to a Q24.24 word.
  function automatic q_t sat_q(input opa_t v);
    if (v[AW_OP-1:QW-1] == '0 || v[AW_OP-1:QW-1] == '1) begin
      return v[QW-1:0];
    end
    return v[AW_OP-1] ? QMIN : QMAX;
  endfunction

  function automatic logic [QW-1:0] mag_q(input q_t v);
    return v[QW-1] ? (~v + 1'b1) : v;
  endfunction

endpackage

### rtl/core/rrt_ram.sv
// ----------------------------------------------------------------------------
// rrt_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module rrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/rrt_mac.sv
// ----------------------------------------------------------------------------
// rrt_mac
// Sequential signed multiply-accumulate of one or three products, floored
// by 2^24 and saturated to Q24.24. One 50x16 partial product per cycle.
// ----------------------------------------------------------------------------
module rrt_mac import rrt_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  mac_req_t                    req,
  input  logic [2:0][AW_OP-1:0]       op_a,
  input  logic [2:0][QW-1:0]          op_b,
  output mac_rsp_t                    rsp
);

  localparam int CH   = 16;
  localparam int NCH  = QW / CH;
  localparam int CHW  = $clog2(NCH);
  localparam int PPW  = AW_OP + CH;
  localparam int ACCW = AW_OP + QW + 2;

  logic [2:0][AW_OP-1:0]   a_r;
  logic [2:0][QW-1:0]      b_r;
  logic                    busy_r, pp_v_r, pp_last_r, fin_r, pp_neg_r;
  logic [1:0]              term_r, last_term_r;
  logic [CHW-1:0]          chunk_r, pp_sh_r;
  logic [PPW-1:0]          pp_r;
  logic signed [ACCW-1:0]  acc_r;

  logic [AW_OP-1:0]        a_sel, a_mag;
  logic [QW-1:0]           b_sel, b_mag;
  logic [CH-1:0]           b_chunk;
  logic [PPW-1:0]          pp_nxt;
  logic [ACCW-1:0]         pp_shifted;
  logic signed [ACCW-1:0]  acc_nxt, acc_fl;
  logic                    step_end;

  always_comb begin
    a_sel      = a_r[term_r];
    b_sel      = b_r[term_r];
    a_mag      = a_sel[AW_OP-1] ? (~a_sel + 1'b1) : a_sel;
    b_mag      = b_sel[QW-1] ? (~b_sel + 1'b1) : b_sel;
    b_chunk    = b_mag[CH*chunk_r +: CH];
    pp_nxt     = PPW'(a_mag) * PPW'(b_chunk);
    step_end   = (chunk_r == CHW'(NCH-1)) && (term_r == last_term_r);
    pp_shifted = ACCW'(pp_r) << (CH*pp_sh_r);
    acc_nxt    = pp_neg_r ? acc_r - $signed(pp_shifted) : acc_r + $signed(pp_shifted);
    acc_fl     = acc_r >>> FRAC;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      pp_v_r    <= 1'b0;
      pp_last_r <= 1'b0;
      fin_r     <= 1'b0;
    end else begin
      pp_v_r    <= busy_r;
      pp_last_r <= busy_r && step_end;
      fin_r     <= pp_last_r;
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_end) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      a_r         <= op_a;
      b_r         <= op_b;
      term_r      <= 2'd0;
      chunk_r     <= '0;
      last_term_r <= req.dot ? 2'd2 : 2'd0;
      acc_r       <= '0;
    end else begin
      if (busy_r) begin
        if (chunk_r == CHW'(NCH-1)) begin
          chunk_r <= '0;
          term_r  <= term_r + 2'd1;
        end else begin
          chunk_r <= chunk_r + 1'b1;
        end
      end
      if (pp_v_r) begin
        acc_r <= acc_nxt;
      end
    end
    pp_r     <= pp_nxt;
    pp_neg_r <= a_sel[AW_OP-1] ^ b_sel[QW-1];
    pp_sh_r  <= chunk_r;
  end

  always_comb begin
    rsp.done = fin_r;
    if (acc_fl[ACCW-1:QW-1] == '0 || acc_fl[ACCW-1:QW-1] == '1) begin
      rsp.res = acc_fl[QW-1:0];
    end else begin
      rsp.res = acc_fl[ACCW-1] ? QMIN : QMAX;
    end
  end

endmodule

### rtl/core/rrt_div.sv
// ----------------------------------------------------------------------------
// rrt_div
// Restoring divider for (num * 2^24) / den on magnitudes, one quotient bit
// per cycle, quotient clamped at 2^48.
// ----------------------------------------------------------------------------
module rrt_div import rrt_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  localparam int DVW = QW + FRAC;
  localparam int CNW = $clog2(DVW);

  logic [DVW-1:0] dvd_r;
  logic [QW-1:0]  den_r, rem_r;
  logic [QW:0]    q_r;
  logic [CNW-1:0] cnt_r;
  logic           busy_r, fin_r;

  logic [QW:0]    rem_s, rem_d;
  logic [QW+1:0]  q_s, q_cap;
  logic           ge;

  always_comb begin
    rem_s = {rem_r, dvd_r[DVW-1]};
    ge    = rem_s >= {1'b0, den_r};
    rem_d = ge ? rem_s - {1'b0, den_r} : rem_s;
    q_s   = {q_r, ge};
    q_cap = (QW+2)'(1) << QW;
    if (q_s > q_cap) begin
      q_s = q_cap;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
    end else begin
      fin_r <= busy_r && (cnt_r == '0);
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && (cnt_r == '0)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dvd_r <= {req.num_mag, {FRAC{1'b0}}};
      den_r <= req.den_mag;
      rem_r <= '0;
      q_r   <= '0;
      cnt_r <= CNW'(DVW-1);
    end else if (busy_r) begin
      dvd_r <= dvd_r << 1;
      rem_r <= rem_d[QW-1:0];
      q_r   <= q_s[QW:0];
      cnt_r <= cnt_r - 1'b1;
    end
  end

  assign rsp.done = fin_r;
  assign rsp.quot = q_r;

endmodule

### rtl/core/reflection_ray_tracer.sv
// ----------------------------------------------------------------------------
// reflection_ray_tracer
// Specular ray tracer over a table of rectangular reflectors.
// ----------------------------------------------------------------------------
// A word with func 0 writes one reflector word (center, normal, length axis,
// width axis or sizes) into the reflector RAM and gives no result; the RAM is
// not cleared at reset, so every slot in use must be written before a trace.
// A word with func 1 traces a ray and gives one result word per segment, the
// final one with tlast set. Each segment scans the patches in use one after
// another; the work per patch is set mainly by the 72-step restoring divider
// for the hit distance and by the shared multiplier, which forms one 50x16
// partial product per cycle; a segment's time grows with the number of patches
// in use. Input is taken only between traces; a finished result may wait in the
// output register while the next word is accepted.
// ----------------------------------------------------------------------------
module reflection_ray_tracer import rrt_pkg::*; #(
  parameter int MAX_SURFACES = MAX_SURFACES_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [1:0]   cfg_index,
  input  logic [46:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // slot, ax, ay, az, dir_x, dir_y, dir_z from bit 0 up, zero padded
  input  logic [295:0] in_tdata,
  // func, word_select from bit 0 up
  input  logic [3:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // end_x, end_y, end_z, hit_surface from bit 0 up, zero padded
  output logic [151:0] out_tdata,
  // status
  output logic [2:0]   out_tuser,
  output logic         out_tlast
);

  localparam int SW    = $clog2(MAX_SURFACES);
  localparam int CW    = $clog2(MAX_SURFACES + 1);
  localparam int RAW   = SW + 3;
  localparam int DEPTH = MAX_SURFACES * 8;

  localparam logic [4:0] S_IDLE   = 5'd0,  S_PCHK   = 5'd1,  S_RDC  = 5'd2;
  localparam logic [4:0] S_RDN    = 5'd3,  S_DEN_GO = 5'd4,  S_DEN_W = 5'd5;
  localparam logic [4:0] S_NUM_GO = 5'd6,  S_NUM_W  = 5'd7,  S_DIV_GO = 5'd8;
  localparam logic [4:0] S_DIV_W  = 5'd9,  S_R_GO   = 5'd10, S_R_W  = 5'd11;
  localparam logic [4:0] S_RDL    = 5'd12, S_L_GO   = 5'd13, S_L_W  = 5'd14;
  localparam logic [4:0] S_RDW    = 5'd15, S_W_GO   = 5'd16, S_W_W  = 5'd17;
  localparam logic [4:0] S_SZ     = 5'd18, S_EVAL   = 5'd19, S_Q_GO = 5'd20;
  localparam logic [4:0] S_Q_W    = 5'd21, S_EMIT   = 5'd22, S_RFN  = 5'd23;
  localparam logic [4:0] S_D_GO   = 5'd24, S_D_W    = 5'd25;

  // Input word fields.
  logic          in_func;
  logic [2:0]    in_ws;
  logic [3:0]    in_slot;
  logic [2:0][QW-1:0] in_a, in_d;

  assign in_func = in_tuser[0];
  assign in_ws   = in_tuser[3:1];
  assign in_slot = in_tdata[3:0];
  assign in_a    = in_tdata[4 +: 3*QW];
  assign in_d    = in_tdata[4+3*QW +: 3*QW];

  // Configuration registers.
  logic [4:0]  cnt_cfg_r;
  logic [3:0]  maxr_cfg_r;
  logic [46:0] reach_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_cfg_r  <= COUNT_RST;
      maxr_cfg_r <= MAXREF_RST;
      reach_r    <= REACH_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_COUNT:  cnt_cfg_r  <= cfg_wdata[4:0];
        CFG_MAXREF: maxr_cfg_r <= cfg_wdata[3:0];
        CFG_REACH:  reach_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Trace state.
  logic [4:0]               state_r, state_nxt;
  logic [CW-1:0]            k_r, k_nxt, count_r, count_nxt;
  logic [1:0]               i_r, i_nxt;
  logic [SW-1:0]            prev_r, prev_nxt, best_r, best_nxt;
  logic                     prev_v_r, prev_v_nxt, best_v_r, best_v_nxt;
  logic                     nohit_r, nohit_nxt;
  logic [3:0]               nref_r, nref_nxt, maxr_r, maxr_nxt;
  logic [2:0][QW-1:0]       p_r, p_nxt, d_r, d_nxt, q_r, q_nxt, vec_r, vec_nxt;
  logic [2:0][QW:0]         e_r, e_nxt;
  logic [2:0][AW_OP-1:0]    r_r, r_nxt;
  q_t                       den_r, den_nxt, num_r, num_nxt, t_r, t_nxt;
  q_t                       lt_r, lt_nxt, wt_r, wt_nxt, bt_r, bt_nxt, bden_r, bden_nxt;

  // Output register.
  logic                     out_valid_r, out_valid_nxt, out_load;
  logic [2:0][QW-1:0]       out_end_r;
  logic [4:0]               out_hit_r;
  logic [2:0]               out_status_r, emit_status;
  logic                     out_last_r, emit_last;

  // Units.
  logic                     ram_we;
  logic [RAW-1:0]           ram_waddr, ram_raddr;
  logic [SW-1:0]            rd_slot;
  logic [2:0]               rd_ws;
  logic [3*QW-1:0]          ram_rdata;
  logic [2:0][QW-1:0]       rd_vec;
  mac_req_t                 mac_req;
  mac_rsp_t                 mac_rsp;
  logic [2:0][AW_OP-1:0]    mac_a;
  logic [2:0][QW-1:0]       mac_b;
  div_req_t                 div_req;
  div_rsp_t                 div_rsp;

  logic [QW-1:0]            len_w, wid_w;
  logic [QW-1:0]            lt_mag, wt_mag;
  logic                     size_miss;
  opa_t                     refl_f;

  assign rd_vec = ram_rdata;

  // Writes land only while idle; reads are issued one state ahead of use.
  assign ram_we    = (state_r == S_IDLE) && in_tvalid && !in_func &&
                     (in_ws <= WS_SIZES) && (32'(in_slot) < MAX_SURFACES);
  assign ram_waddr = {SW'(in_slot), in_ws};
  assign ram_raddr = {rd_slot, rd_ws};

  always_comb begin
    rd_slot = k_r[SW-1:0];
    rd_ws   = WS_CENTER;
    unique case (state_r)
      S_RDC:   rd_ws = WS_NORMAL;
      S_R_W:   rd_ws = WS_LAXIS;
      S_L_W:   rd_ws = WS_WAXIS;
      S_W_W:   rd_ws = WS_SIZES;
      S_EMIT:  begin
        rd_slot = best_r;
        rd_ws   = WS_NORMAL;
      end
      default: rd_ws = WS_CENTER;
    endcase
  end

  rrt_ram #(
    .WIDTH (3*QW),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_a),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rrt_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mac_req),
    .op_a  (mac_a),
    .op_b  (mac_b),
    .rsp   (mac_rsp)
  );

  rrt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Reflection factor -2 * (d.n) of the chosen patch.
  assign refl_f = -(sx_op(bden_r) <<< 1);

  // Multiplier operand selection by phase.
  always_comb begin
    mac_a       = '0;
    mac_b       = '0;
    mac_req     = '0;
    unique case (state_r)
      S_DEN_GO: begin
        mac_req = '{start: 1'b1, dot: 1'b1};
        for (int j = 0; j < 3; j++) mac_a[j] = sx_op(d_r[j]);
        mac_b = vec_r;
      end
      S_NUM_GO: begin
        mac_req = '{start: 1'b1, dot: 1'b1};
        for (int j = 0; j < 3; j++) mac_a[j] = {e_r[j][QW], e_r[j]};
        mac_b = vec_r;
      end
      S_R_GO: begin
        mac_req  = '{start: 1'b1, dot: 1'b0};
        mac_a[0] = sx_op(t_r);
        mac_b[0] = d_r[i_r];
      end
      S_L_GO, S_W_GO: begin
        mac_req = '{start: 1'b1, dot: 1'b1};
        mac_a   = r_r;
        mac_b   = vec_r;
      end
      S_Q_GO: begin
        mac_req  = '{start: 1'b1, dot: 1'b0};
        mac_a[0] = sx_op(bt_r);
        mac_b[0] = d_r[i_r];
      end
      S_D_GO: begin
        mac_req  = '{start: 1'b1, dot: 1'b0};
        mac_a[0] = refl_f;
        mac_b[0] = vec_r[i_r];
      end
      default: mac_req = '0;
    endcase
  end

  always_comb begin
    div_req.start   = (state_r == S_DIV_GO);
    div_req.num_mag = mag_q(num_r);
    div_req.den_mag = mag_q(den_r);
  end

  // Bounds test of the hit point against the patch sizes; a negative size
  // never passes.
  always_comb begin
    len_w     = rd_vec[0];
    wid_w     = rd_vec[1];
    lt_mag    = mag_q(lt_r);
    wt_mag    = mag_q(wt_r);
    size_miss = len_w[QW-1] || wid_w[QW-1] ||
                ({lt_mag, 1'b0} > {1'b0, len_w}) ||
                ({wt_mag, 1'b0} > {1'b0, wid_w});
  end

  // Segment outcome.
  always_comb begin
    emit_last = 1'b1;
    priority if (nohit_r) begin
      emit_status = ST_NOHIT;
    end else if (bden_r > 0) begin
      emit_status = ST_BLOCKED;
    end else if (CW'(best_r) == count_r - 1'b1) begin
      emit_status = ST_DEST;
    end else if (nref_r > maxr_r) begin
      emit_status = ST_LIMIT;
    end else begin
      emit_status = ST_REFLECT;
      emit_last   = 1'b0;
    end
  end

  assign in_tready = (state_r == S_IDLE);
  assign out_load  = (state_r == S_EMIT) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt  = state_r;
    k_nxt      = k_r;
    i_nxt      = i_r;
    count_nxt  = count_r;
    maxr_nxt   = maxr_r;
    prev_nxt   = prev_r;
    prev_v_nxt = prev_v_r;
    best_nxt   = best_r;
    best_v_nxt = best_v_r;
    nohit_nxt  = nohit_r;
    nref_nxt   = nref_r;
    p_nxt      = p_r;
    d_nxt      = d_r;
    q_nxt      = q_r;
    vec_nxt    = vec_r;
    e_nxt      = e_r;
    r_nxt      = r_r;
    den_nxt    = den_r;
    num_nxt    = num_r;
    t_nxt      = t_r;
    lt_nxt     = lt_r;
    wt_nxt     = wt_r;
    bt_nxt     = bt_r;
    bden_nxt   = bden_r;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_func) begin
          p_nxt      = in_a;
          d_nxt      = in_d;
          k_nxt      = '0;
          prev_v_nxt = 1'b0;
          best_v_nxt = 1'b0;
          nref_nxt   = '0;
          maxr_nxt   = (maxr_cfg_r > MAXREF_CAP) ? MAXREF_CAP : maxr_cfg_r;
          if (cnt_cfg_r == 5'd0) begin
            count_nxt = CW'(1);
          end else if (32'(cnt_cfg_r) > MAX_SURFACES) begin
            count_nxt = CW'(MAX_SURFACES);
          end else begin
            count_nxt = CW'(cnt_cfg_r);
          end
          state_nxt = S_PCHK;
        end
      end
      S_PCHK: begin
        if (k_r == count_r) begin
          state_nxt = S_EVAL;
        end else if (prev_v_r && (k_r[SW-1:0] == prev_r)) begin
          k_nxt = k_r + 1'b1;
        end else begin
          state_nxt = S_RDC;
        end
      end
      S_RDC: begin
        for (int j = 0; j < 3; j++) begin
          e_nxt[j] = $signed({p_r[j][QW-1], p_r[j]}) - $signed({rd_vec[j][QW-1], rd_vec[j]});
        end
        state_nxt = S_RDN;
      end
      S_RDN: begin
        vec_nxt   = rd_vec;
        state_nxt = S_DEN_GO;
      end
      S_DEN_GO: state_nxt = S_DEN_W;
      S_DEN_W: begin
        if (mac_rsp.done) begin
          den_nxt = mac_rsp.res;
          if (mac_rsp.res == '0) begin
            // Ray parallel to the patch: a miss.
            k_nxt     = k_r + 1'b1;
            state_nxt = S_PCHK;
          end else begin
            state_nxt = S_NUM_GO;
          end
        end
      end
      S_NUM_GO: state_nxt = S_NUM_W;
      S_NUM_W: begin
        if (mac_rsp.done) begin
          num_nxt   = (mac_rsp.res == QMIN) ? QMAX : -mac_rsp.res;
          state_nxt = S_DIV_GO;
        end
      end
      S_DIV_GO: state_nxt = S_DIV_W;
      S_DIV_W: begin
        if (div_rsp.done) begin
          if ((num_r[QW-1] ^ den_r[QW-1]) && (div_rsp.quot != '0)) begin
            // Patch lies behind the origin.
            k_nxt     = k_r + 1'b1;
            state_nxt = S_PCHK;
          end else begin
            t_nxt     = (div_rsp.quot[QW:QW-1] != 2'b00) ? QMAX : div_rsp.quot[QW-1:0];
            i_nxt     = 2'd0;
            state_nxt = S_R_GO;
          end
        end
      end
      S_R_GO: state_nxt = S_R_W;
      S_R_W: begin
        if (mac_rsp.done) begin
          r_nxt[i_r] = $signed({e_r[i_r][QW], e_r[i_r]}) + sx_op(mac_rsp.res);
          if (i_r == 2'd2) begin
            i_nxt     = 2'd0;
            state_nxt = S_RDL;
          end else begin
            i_nxt     = i_r + 2'd1;
            state_nxt = S_R_GO;
          end
        end
      end
      S_RDL: begin
        vec_nxt   = rd_vec;
        state_nxt = S_L_GO;
      end
      S_L_GO: state_nxt = S_L_W;
      S_L_W: begin
        if (mac_rsp.done) begin
          lt_nxt    = mac_rsp.res;
          state_nxt = S_RDW;
        end
      end
      S_RDW: begin
        vec_nxt   = rd_vec;
        state_nxt = S_W_GO;
      end
      S_W_GO: state_nxt = S_W_W;
      S_W_W: begin
        if (mac_rsp.done) begin
          wt_nxt    = mac_rsp.res;
          state_nxt = S_SZ;
        end
      end
      S_SZ: begin
        // Strict compare keeps the lower index on a tie.
        if (!size_miss && (!best_v_r || (t_r < bt_r))) begin
          best_nxt   = k_r[SW-1:0];
          best_v_nxt = 1'b1;
          bt_nxt     = t_r;
          bden_nxt   = den_r;
        end
        k_nxt     = k_r + 1'b1;
        state_nxt = S_PCHK;
      end
      S_EVAL: begin
        if (!best_v_r || ({1'b0, bt_r} > {2'b00, reach_r})) begin
          nohit_nxt = 1'b1;
          state_nxt = S_EMIT;
        end else begin
          nohit_nxt = 1'b0;
          i_nxt     = 2'd0;
          state_nxt = S_Q_GO;
        end
      end
      S_Q_GO: state_nxt = S_Q_W;
      S_Q_W: begin
        if (mac_rsp.done) begin
          q_nxt[i_r] = sat_q(sx_op(p_r[i_r]) + sx_op(mac_rsp.res));
          if (i_r == 2'd2) begin
            i_nxt     = 2'd0;
            state_nxt = S_EMIT;
          end else begin
            i_nxt     = i_r + 2'd1;
            state_nxt = S_Q_GO;
          end
        end
      end
      S_EMIT: begin
        if (out_load) begin
          state_nxt = emit_last ? S_IDLE : S_RFN;
        end
      end
      S_RFN: begin
        vec_nxt   = rd_vec;
        p_nxt     = q_r;
        i_nxt     = 2'd0;
        state_nxt = S_D_GO;
      end
      S_D_GO: state_nxt = S_D_W;
      S_D_W: begin
        if (mac_rsp.done) begin
          d_nxt[i_r] = sat_q(sx_op(d_r[i_r]) + sx_op(mac_rsp.res));
          if (i_r == 2'd2) begin
            i_nxt      = 2'd0;
            prev_nxt   = best_r;
            prev_v_nxt = 1'b1;
            nref_nxt   = nref_r + 4'd1;
            k_nxt      = '0;
            best_v_nxt = 1'b0;
            state_nxt  = S_PCHK;
          end else begin
            i_nxt     = i_r + 2'd1;
            state_nxt = S_D_GO;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      prev_v_r    <= 1'b0;
      best_v_r    <= 1'b0;
      nohit_r     <= 1'b0;
      k_r         <= '0;
      i_r         <= '0;
      nref_r      <= '0;
      count_r     <= CW'(1);
      maxr_r      <= MAXREF_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      prev_v_r    <= prev_v_nxt;
      best_v_r    <= best_v_nxt;
      nohit_r     <= nohit_nxt;
      k_r         <= k_nxt;
      i_r         <= i_nxt;
      nref_r      <= nref_nxt;
      count_r     <= count_nxt;
      maxr_r      <= maxr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    prev_r <= prev_nxt;
    best_r <= best_nxt;
    p_r    <= p_nxt;
    d_r    <= d_nxt;
    q_r    <= q_nxt;
    vec_r  <= vec_nxt;
    e_r    <= e_nxt;
    r_r    <= r_nxt;
    den_r  <= den_nxt;
    num_r  <= num_nxt;
    t_r    <= t_nxt;
    lt_r   <= lt_nxt;
    wt_r   <= wt_nxt;
    bt_r   <= bt_nxt;
    bden_r <= bden_nxt;
    if (out_load) begin
      out_end_r    <= nohit_r ? '0 : q_r;
      out_hit_r    <= nohit_r ? 5'(MAX_SURFACES) : 5'(best_r);
      out_status_r <= emit_status;
      out_last_r   <= emit_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_hit_r, out_end_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

  // The multiplier answers only while the sequencer waits for it.
  a_mac_owner: assert property (@(posedge clk) disable iff (!rst_n)
    mac_rsp.done |-> (state_r == S_DEN_W || state_r == S_NUM_W || state_r == S_R_W ||
                      state_r == S_L_W || state_r == S_W_W || state_r == S_Q_W ||
                      state_r == S_D_W))
    else $error("multiplier result outside a wait state");

  a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == S_DIV_W)
    else $error("divider result outside its wait state");

  // A segment that does not close the trace must be a reflection.
  a_mid_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_last_r) |-> out_status_r == ST_REFLECT)
    else $error("non-final segment with a terminal status");

  // A hit end point is emitted only with a chosen patch.
  a_emit_best: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT && !nohit_r) |-> best_v_r)
    else $error("hit segment without a chosen patch");

  a_nref_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SZ) |-> nref_r <= maxr_r + 4'd1)
    else $error("reflection count beyond the limit");

endmodule

### bench/reflection_ray_tracer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// reflection_ray_tracer_tb
// Self-checking bench for the reflector table and the specular ray tracer.
// Scenes of mirrors, obstacles and a destination wall are loaded word by
// word, rays are traced under several register settings, and every segment
// word is compared with a bit-exact Q24.24 predictor kept in a scoreboard.
// ----------------------------------------------------------------------------
module reflection_ray_tracer_tb;
  import rrt_pkg::*;

  typedef logic signed [63:0]  s64_t;
  typedef logic signed [127:0] w_t;
  typedef s64_t v3_t [3];

  // One input word as the driver sees it.
  typedef struct {
    bit       func;
    bit [3:0] slot;
    bit [2:0] sel;
    q_t       ax, ay, az;
    q_t       dx, dy, dz;
  } ray_word_t;

  // One segment word on the result side.
  typedef struct {
    q_t       ex, ey, ez;
    bit [4:0] surf;
    bit [2:0] status;
    bit       last;
  } segment_t;

  localparam int  NSURF = MAX_SURFACES_DEF;
  localparam q_t  ONE   = 48'sd16777216;

  // --------------------------------------------------------------------------
  // Scoreboard: holds a copy of the reflector table and the registers, works
  // out the segments of every accepted trace and checks the result words.
  // --------------------------------------------------------------------------
  class trace_scoreboard;
    q_t       store [NSURF][5][3];
    bit [4:0] count_reg;
    bit [3:0] maxref_reg;
    bit [46:0] reach_reg;
    segment_t pending [$];
    int n_checked, n_err, n_traces, n_writes, n_status [5];

    function new();
      foreach (store[i, j, k]) store[i][j][k] = '0;
      count_reg  = COUNT_RST;
      maxref_reg = MAXREF_RST;
      reach_reg  = REACH_RST;
    endfunction

    function void set_reg(logic [1:0] idx, logic [46:0] v);
      case (idx)
        CFG_COUNT:  count_reg  = v[4:0];
        CFG_MAXREF: maxref_reg = v[3:0];
        CFG_REACH:  reach_reg  = v;
        default: ;
      endcase
    endfunction

    // Saturate a wide value to the signed 48-bit range.
    function q_t clip(w_t v);
      if (v > w_t'(QMAX)) return QMAX;
      if (v < w_t'(QMIN)) return QMIN;
      return v[47:0];
    endfunction

    // Exact product, floor shift by the fraction width, then saturation.
    function q_t qmul(s64_t a, s64_t b);
      w_t prod;
      prod = w_t'(a) * w_t'(b);
      return clip(prod >>> FRAC);
    endfunction

    function q_t dot3(v3_t a, v3_t b);
      w_t acc;
      acc = w_t'(a[0]) * w_t'(b[0]) + w_t'(a[1]) * w_t'(b[1]) + w_t'(a[2]) * w_t'(b[2]);
      return clip(acc >>> FRAC);
    endfunction

    // Quotient truncates toward zero, as the hardware divider does.
    function q_t qdiv(q_t num, q_t den);
      w_t quo;
      quo = (w_t'(num) <<< FRAC) / w_t'(den);
      return clip(quo);
    endfunction

    function v3_t word_of(int k, int sel);
      v3_t v;
      for (int i = 0; i < 3; i++) v[i] = s64_t'(store[k][sel][i]);
      return v;
    endfunction

    function bit patch_hit(int k, v3_t p, v3_t d, output q_t t, output q_t den);
      v3_t  e, r, nrm;
      q_t   num, lt, wt;
      s64_t ml, mw;
      nrm = word_of(k, WS_NORMAL);
      for (int i = 0; i < 3; i++) e[i] = p[i] - s64_t'(store[k][WS_CENTER][i]);
      den = dot3(d, nrm);
      if (den == 0) return 0;
      num = clip(-w_t'(dot3(e, nrm)));
      t = qdiv(num, den);
      if (t < 0) return 0;
      for (int i = 0; i < 3; i++) r[i] = e[i] + s64_t'(qmul(t, d[i]));
      lt = dot3(r, word_of(k, WS_LAXIS));
      wt = dot3(r, word_of(k, WS_WAXIS));
      ml = lt < 0 ? -s64_t'(lt) : s64_t'(lt);
      mw = wt < 0 ? -s64_t'(wt) : s64_t'(wt);
      if (2 * ml > s64_t'(store[k][WS_SIZES][0])) return 0;
      if (2 * mw > s64_t'(store[k][WS_SIZES][1])) return 0;
      return 1;
    endfunction

    // Called for every accepted input word.
    function void note_input(ray_word_t w);
      v3_t      p, d, nrm;
      int       cnt, mx, prev, best, nref;
      q_t       bt, bden, t, den;
      q_t       hitp [3];
      s64_t     f;
      segment_t seg;
      if (!w.func) begin
        n_writes++;
        if (w.sel <= WS_SIZES) begin
          store[w.slot][w.sel][0] = w.ax;
          store[w.slot][w.sel][1] = w.ay;
          store[w.slot][w.sel][2] = w.az;
        end
        return;
      end
      n_traces++;
      cnt = count_reg == 0 ? 1 : (count_reg > NSURF ? NSURF : count_reg);
      mx = maxref_reg > MAXREF_CAP ? MAXREF_CAP : maxref_reg;
      p = '{s64_t'(w.ax), s64_t'(w.ay), s64_t'(w.az)};
      d = '{s64_t'(w.dx), s64_t'(w.dy), s64_t'(w.dz)};
      prev = -1;
      nref = 0;
      forever begin
        best = -1;
        bt = 0;
        bden = 0;
        for (int k = 0; k < cnt; k++) begin
          if (k != prev && patch_hit(k, p, d, t, den) && (best < 0 || t < bt)) begin
            best = k;
            bt = t;
            bden = den;
          end
        end
        if (best < 0 || s64_t'(bt) > s64_t'({17'b0, reach_reg})) begin
          seg = '{ex: 0, ey: 0, ez: 0, surf: NSURF, status: ST_NOHIT, last: 1};
          pending.push_back(seg);
          return;
        end
        for (int i = 0; i < 3; i++) hitp[i] = clip(w_t'(p[i]) + w_t'(qmul(bt, d[i])));
        seg = '{ex: hitp[0], ey: hitp[1], ez: hitp[2], surf: best[4:0],
                status: ST_REFLECT, last: 1};
        // Blocked wins over destination, destination over the bounce limit.
        if (bden > 0) seg.status = ST_BLOCKED;
        else if (best == cnt - 1) seg.status = ST_DEST;
        else if (nref > mx) seg.status = ST_LIMIT;
        else seg.last = 0;
        pending.push_back(seg);
        if (seg.last) return;
        // Mirror the direction about the patch normal and go on from the hit.
        f = -2 * s64_t'(bden);
        nrm = word_of(best, WS_NORMAL);
        for (int i = 0; i < 3; i++) begin
          p[i] = s64_t'(hitp[i]);
          d[i] = s64_t'(clip(w_t'(d[i]) + w_t'(qmul(f, nrm[i]))));
        end
        prev = best;
        nref++;
      end
    endfunction

    function void check(segment_t got);
      segment_t want;
      if (pending.size() == 0) begin
        n_err++;
        if (n_err <= 10)
          $display("ERROR: unexpected segment word surf=%0d status=%0d", got.surf, got.status);
        return;
      end
      want = pending.pop_front();
      n_checked++;
      if (got.status < 5) n_status[got.status]++;
      if (got.ex !== want.ex || got.ey !== want.ey || got.ez !== want.ez ||
          got.surf !== want.surf || got.status !== want.status || got.last !== want.last) begin
        n_err++;
        if (n_err <= 10) begin
          $display("ERROR: segment mismatch at %0t", $time);
          $display("  expected end=(%0d,%0d,%0d) surf=%0d status=%0d last=%0d",
                   want.ex, want.ey, want.ez, want.surf, want.status, want.last);
          $display("  actual   end=(%0d,%0d,%0d) surf=%0d status=%0d last=%0d",
                   got.ex, got.ey, got.ez, got.surf, got.status, got.last);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and the block itself.
  // --------------------------------------------------------------------------
  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         cfg_we = 1'b0;
  logic [1:0]   cfg_index = '0;
  logic [46:0]  cfg_wdata = '0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [295:0] in_tdata = '0;
  logic [3:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [151:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         out_tlast;

  trace_scoreboard sb = new();

  always #5 clk = ~clk;

  reflection_ray_tracer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  // --------------------------------------------------------------------------
  // Result side: the receiver switches between four stall patterns, picked at
  // random, one of which never stalls. Handshakes are sampled at the edge,
  // before the block updates its outputs.
  // --------------------------------------------------------------------------
  logic [15:0] stall_ctr = '0;
  logic [1:0]  stall_mode = '0;

  always @(posedge clk) begin
    stall_ctr <= stall_ctr + 1'b1;
    if (stall_ctr[6:0] == 0) stall_mode <= 2'($urandom_range(0, 3));
    case (stall_mode)
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= 1'($urandom_range(0, 1));
      2'd2: out_tready <= (stall_ctr[2:0] != 0);
      default: out_tready <= (stall_ctr[4:0] > 5'd20);
    endcase
  end

  always @(posedge clk) begin
    segment_t got;
    if (rst_n && out_tvalid && out_tready) begin
      got.ex = out_tdata[47:0];
      got.ey = out_tdata[95:48];
      got.ez = out_tdata[143:96];
      got.surf = out_tdata[148:144];
      got.status = out_tuser;
      got.last = out_tlast;
      sb.check(got);
    end
  end

  // --------------------------------------------------------------------------
  // Input side. The sender works in bursts; between bursts valid may drop for
  // a random gap. Valid is only lowered when a real gap follows, so back-to-back
  // words never see a low and a high in the same step.
  // --------------------------------------------------------------------------
  int burst_left = 0;

  task automatic push_word(ray_word_t w);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 4) == 0 ? 40 : $urandom_range(1, 6);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {4'b0, w.dz, w.dy, w.dx, w.az, w.ay, w.ax, w.slot};
    in_tuser <= {w.sel, w.func};
    do @(posedge clk); while (!in_tready);
    sb.note_input(w);
    burst_left--;
  endtask

  task automatic put_slot(int slot, logic [2:0] sel, q_t a, q_t b, q_t c);
    ray_word_t w;
    w = '{func: 0, slot: slot[3:0], sel: sel, ax: a, ay: b, az: c, dx: 0, dy: 0, dz: 0};
    push_word(w);
  endtask

  task automatic trace_ray(q_t px, q_t py, q_t pz, q_t vx, q_t vy, q_t vz);
    ray_word_t w;
    w = '{func: 1, slot: 4'($urandom), sel: 3'($urandom), ax: px, ay: py, az: pz,
          dx: vx, dy: vy, dz: vz};
    push_word(w);
  endtask

  // Full 48-bit random pattern.
  function automatic q_t any48();
    return {16'($urandom), $urandom};
  endfunction

  // Random value in [-span, span] in steps of 1/256.
  function automatic q_t near(int span);
    return (q_t'($urandom_range(0, 512 * span)) - q_t'(256 * span)) <<< 16;
  endfunction

  // Scene: slot 0 is a floor mirror facing up at z = 0, slot 1 a ceiling
  // mirror facing down at z = 4, the others small obstacles of random
  // orientation (some with negative sizes, which can never be hit). The
  // last patch in use is then turned into a wall facing the ray at x = X.
  task automatic build_scene(int dest);
    q_t wall_x;
    put_slot(0, WS_CENTER, 0, 0, 0);
    put_slot(0, WS_NORMAL, 0, 0, ONE);
    put_slot(0, WS_LAXIS, ONE, 0, 0);
    put_slot(0, WS_WAXIS, 0, ONE, 0);
    put_slot(0, WS_SIZES, 400 * ONE, 400 * ONE, 0);
    put_slot(1, WS_CENTER, 0, 0, 4 * ONE);
    put_slot(1, WS_NORMAL, 0, 0, -ONE);
    put_slot(1, WS_LAXIS, ONE, 0, 0);
    put_slot(1, WS_WAXIS, 0, ONE, 0);
    put_slot(1, WS_SIZES, 400 * ONE, 400 * ONE, 0);
    for (int s = 2; s < NSURF; s++) begin
      put_slot(s, WS_CENTER, q_t'($urandom_range(2, 30)) * ONE, near(1),
               q_t'($urandom_range(1, 3)) * ONE);
      put_slot(s, WS_NORMAL, near(1), near(1), near(1));
      put_slot(s, WS_LAXIS, near(1), near(1), near(1));
      put_slot(s, WS_WAXIS, near(1), near(1), near(1));
      put_slot(s, WS_SIZES, near(3), near(3), near(1));
    end
    wall_x = q_t'($urandom_range(4, 30)) * ONE;
    put_slot(dest, WS_CENTER, wall_x, 0, 2 * ONE);
    put_slot(dest, WS_NORMAL, -ONE, 0, 0);
    put_slot(dest, WS_LAXIS, 0, 0, ONE);
    put_slot(dest, WS_WAXIS, 0, ONE, 0);
    put_slot(dest, WS_SIZES, 8 * ONE, 400 * ONE, 0);
  endtask

  // A ray leaving the gap between the mirrors, heading into +x.
  task automatic scene_ray();
    q_t vx, vz;
    vx = q_t'($urandom_range(3, 15)) * (ONE / 16);
    vz = ONE - vx / 3;
    if ($urandom_range(0, 1)) vz = -vz;
    trace_ray(near(1) >>> 1, near(1) >>> 2, 2 * ONE, vx, near(1) >>> 4, vz);
  endtask

  task automatic random_item();
    int pick;
    ray_word_t w;
    pick = $urandom_range(0, 99);
    if (pick < 70) begin
      scene_ray();
    end else if (pick < 82) begin
      trace_ray(near(20), near(5), near(5), near(1), near(1), near(1));
    end else if (pick < 88) begin
      trace_ray(any48(), any48(), any48(), any48(), any48(), any48());
    end else begin
      // Obstacle rewrites, now and then with an unused word select.
      w = '{func: 0, slot: 4'($urandom_range(2, 15)), sel: 3'($urandom_range(0, 7)),
            ax: near(30), ay: near(3), az: near(3), dx: any48(), dy: any48(), dz: any48()};
      push_word(w);
    end
  endtask

  // Waits until every expected segment has come out, then lets the block
  // settle before registers may change.
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [46:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, v);
    @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Main sequence: a directed opening under reset settings, then phases of
  // random words, each phase under its own register setting. The settings
  // include a count of zero and one above the table size, a limit above the
  // cap, and reach limits of zero and of the full range.
  // --------------------------------------------------------------------------
  localparam logic [46:0] REACH_MAX = '1;
  int          phase_count  [8] = '{1, 4, 0, 31, 6, 3, 2, 16};
  int          phase_maxref [8] = '{3, 0, 15, 14, 2, 14, 5, 1};
  logic [46:0] phase_reach  [8];

  initial begin
    int dest, items;
    phase_reach = '{REACH_RST, REACH_MAX, REACH_RST, REACH_MAX, 47'd0, REACH_RST,
                    47'd10 * 47'd16777216, REACH_RST};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int ph = 0; ph < 8; ph++) begin
      if (ph > 0) begin
        write_reg(CFG_COUNT, 47'(phase_count[ph]));
        write_reg(CFG_MAXREF, 47'(phase_maxref[ph]));
        write_reg(CFG_REACH, phase_reach[ph]);
      end
      dest = phase_count[ph] == 0 ? 0 : (phase_count[ph] > NSURF ? NSURF - 1
                                                                 : phase_count[ph] - 1);
      build_scene(dest);
      if (ph == 0) begin
        // Extremes of the ray fields, a zero direction (every denominator
        // zero), and writes with unused word selects, which must change
        // nothing.
        trace_ray(QMAX, QMAX, QMAX, QMAX, QMAX, QMAX);
        trace_ray(QMIN, QMIN, QMIN, QMIN, QMIN, QMIN);
        trace_ray(0, 0, 2 * ONE, 0, 0, 0);
        trace_ray(0, 0, 2 * ONE, 0, 0, -ONE);
        trace_ray(0, 0, -ONE, 0, 0, ONE);
        trace_ray(0, 0, 2 * ONE, 0, 0, QMIN);
        put_slot(15, 3'd5, QMAX, QMIN, QMAX);
        put_slot(15, 3'd6, QMIN, QMAX, QMIN);
        put_slot(15, 3'd7, any48(), any48(), any48());
        scene_ray();
        trace_ray(QMAX, 0, 2 * ONE, QMIN, 0, QMAX);
      end
      items = phase_count[ph] >= NSURF ? 6 : 24;
      for (int i = 0; i < items; i++) random_item();
      drain();
    end

    $display("Traced %0d rays and loaded %0d reflector words over 8 register settings.",
             sb.n_traces, sb.n_writes);
    $display("Checked %0d segments: %0d reflected, %0d destination, %0d blocked, %0d no hit, %0d limit.",
             sb.n_checked, sb.n_status[0], sb.n_status[1], sb.n_status[2],
             sb.n_status[3], sb.n_status[4]);
    if (sb.n_err == 0 && sb.pending.size() == 0) begin
      $display("reflection_ray_tracer verification clean");
    end else begin
      $display("reflection_ray_tracer verification failed");
    end
    $finish;
  end

  // Safety net: far beyond the slowest correct run.
  initial begin
    #200_000_000;
    $display("ERROR: timeout with %0d segments outstanding", sb.pending.size());
    $display("reflection_ray_tracer verification failed");
    $finish;
  end

endmodule

### sim.f
rtl/core/rrt_pkg.sv
rtl/core/rrt_ram.sv
rtl/core/rrt_mac.sv
rtl/core/rrt_div.sv
rtl/core/reflection_ray_tracer.sv
bench/reflection_ray_tracer_tb.sv
